@@ design/rpms_pkg.sv @@
// Shared types, constants and codes for the posture mode sequencer.
`timescale 1ns / 1ps

package rpms_pkg;

    localparam int JOINT_COUNT_DEF = 21;
    localparam int JOINT_W         = 5;
    localparam int ANGLE_W         = 16;
    localparam int GUARD_W         = 16;
    localparam int RAMP_W          = 17;
    localparam int CFG_IDX_W       = 2;
    localparam int EVT_W           = 4;
    localparam int MODE_W          = 3;

    localparam logic [ANGLE_W-1:0] ANGLE_HALF = 16'h8000;
    localparam logic [RAMP_W-1:0]  RAMP_ONE   = 17'h10000;
    localparam logic [GUARD_W-1:0] TICKS_MAX  = 16'hFFFF;

    localparam logic [GUARD_W-1:0] START_GUARD_RST  = 16'd250;
    localparam logic [GUARD_W-1:0] SWITCH_GUARD_RST = 16'd400;
    localparam logic [GUARD_W-1:0] MODE_GUARD_RST   = 16'd100;
    localparam logic [RAMP_W-1:0]  RAMP_INC_RST     = 17'd66;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_GUARD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_GUARD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_GUARD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_INC     = 2'd3;

    // Event codes carried in the mode field of an input item
    localparam logic [EVT_W-1:0] EV_TICK     = 4'd0;
    localparam logic [EVT_W-1:0] EV_SAMPLE   = 4'd1;
    localparam logic [EVT_W-1:0] EV_LOAD_LIE = 4'd2;
    localparam logic [EVT_W-1:0] EV_LOAD_STD = 4'd3;
    localparam logic [EVT_W-1:0] EV_START    = 4'd4;
    localparam logic [EVT_W-1:0] EV_SWITCH   = 4'd5;
    localparam logic [EVT_W-1:0] EV_WALK     = 4'd6;
    localparam logic [EVT_W-1:0] EV_DANCE    = 4'd7;
    localparam logic [EVT_W-1:0] EV_WALK13   = 4'd8;
    localparam logic [EVT_W-1:0] EV_POSITION = 4'd9;
    localparam logic [EVT_W-1:0] EV_STOP     = 4'd10;

    typedef enum logic [MODE_W-1:0] {
        MODE_DEFAULT = 3'd0,
        MODE_LIE     = 3'd1,
        MODE_STAND   = 3'd2,
        MODE_WALK    = 3'd3,
        MODE_DANCE   = 3'd4,
        MODE_WALK13  = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAPTURE,
        ST_READ,
        ST_MULT,
        ST_EMIT,
        ST_WAIT
    } t_state;

    typedef struct packed {
        logic [EVT_W-1:0]          mode;
        logic [JOINT_W-1:0]        joint_index;
        logic signed [ANGLE_W-1:0] position_value;
    } t_in_item;

    typedef struct packed {
        logic [JOINT_W-1:0]        out_joint;
        logic signed [ANGLE_W-1:0] target_position;
        logic                      gain_set;
        logic                      driven;
        logic [MODE_W-1:0]         current_mode;
        logic                      last;
    } t_out_item;

    typedef struct packed {
        logic take_item;
        logic idx_clr;
        logic idx_inc;
        logic cap_step;
        logic rd;
        logic mul;
        logic load_out;
        logic finish_tick;
    } t_cmd;

    typedef struct packed {
        logic item_is_tick;
        logic item_captures;
        logic idx_last;
        logic out_taken;
    } t_sts;

endpackage

@@ design/rpms_ctrl.sv @@
// Controller state machine: sequences events, capture sweeps and per-joint commands.
`timescale 1ns / 1ps

module rpms_ctrl import rpms_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.item_is_tick) begin
                        n_state = ST_READ;
                    end else if (i_sts.item_captures) begin
                        n_state = ST_CAPTURE;
                    end
                end
            end
            ST_CAPTURE: begin
                if (i_sts.idx_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: n_state = ST_MULT;
            ST_MULT: n_state = ST_EMIT;
            ST_EMIT: n_state = ST_WAIT;
            ST_WAIT: begin
                if (i_sts.out_taken) begin
                    n_state = i_sts.idx_last ? ST_IDLE : ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.take_item = i_in_valid;
                o_cmd.idx_clr   = i_in_valid;
            end
            ST_CAPTURE: begin
                o_cmd.cap_step = 1'b1;
                o_cmd.idx_inc  = 1'b1;
            end
            ST_READ: o_cmd.rd = 1'b1;
            ST_MULT: o_cmd.mul = 1'b1;
            ST_EMIT: o_cmd.load_out = 1'b1;
            ST_WAIT: begin
                if (i_sts.out_taken) begin
                    o_cmd.finish_tick = i_sts.idx_last;
                    o_cmd.idx_inc     = !i_sts.idx_last;
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ design/rpms_dp.sv @@
// Datapath: mode state, configuration, joint stores, blend multiplier and output register.
`timescale 1ns / 1ps

module rpms_dp import rpms_pkg::*; #(
    parameter int JOINT_COUNT = JOINT_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_in_item             i_in_data,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RAMP_W-1:0]    i_cfg_data,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output t_out_item            o_out_data,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts
);

    localparam int IDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

    // Configuration
    logic [GUARD_W-1:0] r_start_guard;
    logic [GUARD_W-1:0] r_switch_guard;
    logic [GUARD_W-1:0] r_mode_guard;
    logic [RAMP_W-1:0]  r_ramp_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_guard  <= START_GUARD_RST;
            r_switch_guard <= SWITCH_GUARD_RST;
            r_mode_guard   <= MODE_GUARD_RST;
            r_ramp_inc     <= RAMP_INC_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_GUARD:  r_start_guard  <= i_cfg_data[GUARD_W-1:0];
                CFG_SWITCH_GUARD: r_switch_guard <= i_cfg_data[GUARD_W-1:0];
                CFG_MODE_GUARD:   r_mode_guard   <= i_cfg_data[GUARD_W-1:0];
                CFG_RAMP_INC:     r_ramp_inc     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Mode state
    t_mode              r_mode,    n_mode;
    logic               r_started, n_started;
    logic [RAMP_W-1:0]  r_ramp,    n_ramp;
    logic [GUARD_W-1:0] r_ticks,   n_ticks;
    logic               r_stop,    n_stop;
    logic [IDX_W-1:0]   r_idx;

    logic [EVT_W-1:0]   ev;
    logic [GUARD_W-1:0] guard;
    logic               guarded_ev;
    logic               accepted;
    logic               ev_capture;
    logic [RAMP_W:0]    ramp_sum;
    logic               in_range;
    logic [IDX_W-1:0]   j_idx;

    assign ev       = i_in_data.mode;
    assign in_range = {1'b0, i_in_data.joint_index} < (JOINT_W + 1)'(JOINT_COUNT);
    assign j_idx    = i_in_data.joint_index[IDX_W-1:0];

    always_comb begin
        case (ev)
            EV_START:  guard = r_start_guard;
            EV_SWITCH: guard = r_switch_guard;
            default:   guard = r_mode_guard;
        endcase
        guarded_ev = (ev >= EV_START) && (ev <= EV_POSITION);
        accepted   = guarded_ev && (r_ticks > guard);
    end

    // Events that copy the measured angles into the captured store
    always_comb begin
        ev_capture = 1'b0;
        if (accepted) begin
            case (ev)
                EV_START:    ev_capture = !r_started;
                EV_SWITCH:   ev_capture = r_started && (r_mode == MODE_STAND);
                EV_POSITION: ev_capture = (r_mode == MODE_DEFAULT) || (r_mode == MODE_WALK13);
                default:     ev_capture = 1'b0;
            endcase
        end
    end

    assign ramp_sum = {1'b0, r_ramp} + {1'b0, r_ramp_inc};

    always_comb begin
        n_mode    = r_mode;
        n_started = r_started;
        n_ramp    = r_ramp;
        n_ticks   = r_ticks;
        n_stop    = r_stop;
        if (i_cmd.take_item) begin
            if (ev == EV_STOP) begin
                n_stop = 1'b1;
            end else if (accepted) begin
                n_ticks = '0;
                case (ev)
                    EV_START: begin
                        n_started = !r_started;
                        if (!r_started) begin
                            n_ramp = '0;
                            n_mode = MODE_LIE;
                        end else begin
                            n_mode = MODE_DEFAULT;
                        end
                    end
                    EV_SWITCH: begin
                        if (r_started && r_mode == MODE_STAND) begin
                            n_ramp = '0;
                            n_mode = MODE_LIE;
                        end else if (r_started && r_mode == MODE_LIE) begin
                            n_ramp = '0;
                            n_mode = MODE_STAND;
                        end
                    end
                    EV_WALK: begin
                        if (r_mode == MODE_STAND || r_mode == MODE_WALK13) begin
                            n_mode = MODE_WALK;
                        end
                    end
                    EV_DANCE: begin
                        if (r_mode == MODE_WALK || r_mode == MODE_STAND || r_mode == MODE_LIE) begin
                            n_mode = MODE_DANCE;
                        end
                    end
                    EV_WALK13: begin
                        if (r_mode == MODE_STAND || r_mode == MODE_WALK) begin
                            n_mode = MODE_WALK13;
                        end
                    end
                    default: begin
                        if (r_mode == MODE_WALK) begin
                            n_mode = MODE_STAND;
                        end else if (r_mode == MODE_DEFAULT || r_mode == MODE_WALK13) begin
                            n_ramp = '0;
                            n_mode = MODE_LIE;
                        end
                    end
                endcase
            end
        end
        if (i_cmd.finish_tick) begin
            if (r_mode == MODE_LIE || r_mode == MODE_STAND) begin
                n_ramp = (ramp_sum > {1'b0, RAMP_ONE}) ? RAMP_ONE : ramp_sum[RAMP_W-1:0];
            end
            if (r_stop) begin
                n_stop = 1'b0;
                n_mode = MODE_DEFAULT;
            end
            if (r_ticks != TICKS_MAX) begin
                n_ticks = r_ticks + GUARD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_DEFAULT;
            r_started <= 1'b0;
            r_ramp    <= '0;
            r_ticks   <= TICKS_MAX;
            r_stop    <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_mode    <= n_mode;
            r_started <= n_started;
            r_ramp    <= n_ramp;
            r_ticks   <= n_ticks;
            r_stop    <= n_stop;
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // Measured angles: read as zero until sampled
    logic [ANGLE_W-1:0]     r_meas [JOINT_COUNT];
    logic [JOINT_COUNT-1:0] r_meas_vld;
    logic                   meas_we;
    logic                   lie_we;
    logic                   std_we;

    assign meas_we = i_cmd.take_item && (ev == EV_SAMPLE) && in_range;
    assign lie_we  = i_cmd.take_item && (ev == EV_LOAD_LIE) && in_range;
    assign std_we  = i_cmd.take_item && (ev == EV_LOAD_STD) && in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meas_vld <= '0;
        end else if (meas_we) begin
            r_meas_vld[j_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (meas_we) begin
            r_meas[j_idx] <= i_in_data.position_value;
        end
    end

    // Captured, lie and stand stores
    logic [ANGLE_W-1:0] r_cap_mem [JOINT_COUNT];
    logic [ANGLE_W-1:0] r_lie_mem [JOINT_COUNT];
    logic [ANGLE_W-1:0] r_std_mem [JOINT_COUNT];
    logic [ANGLE_W-1:0] r_cap_rd;
    logic [ANGLE_W-1:0] r_lie_rd;
    logic [ANGLE_W-1:0] r_std_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_step) begin
            r_cap_mem[r_idx] <= r_meas_vld[r_idx] ? r_meas[r_idx] : '0;
        end
        if (i_cmd.rd) begin
            r_cap_rd <= r_cap_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (lie_we) begin
            r_lie_mem[j_idx] <= i_in_data.position_value;
        end
        if (i_cmd.rd) begin
            r_lie_rd <= r_lie_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (std_we) begin
            r_std_mem[j_idx] <= i_in_data.position_value;
        end
        if (i_cmd.rd) begin
            r_std_rd <= r_std_mem[r_idx];
        end
    end

    // Blend: base*(1-f) + goal*f == base + (goal-base)*f, in offset binary
    logic [ANGLE_W-1:0]         blend_a;
    logic [ANGLE_W-1:0]         blend_b;
    logic signed [ANGLE_W:0]    diff;
    logic signed [ANGLE_W+RAMP_W+1:0] r_prod;
    logic [ANGLE_W-1:0]         r_base;
    logic [2*ANGLE_W+3:0]       blend_sum;
    logic [ANGLE_W-1:0]         blend_out;

    always_comb begin
        if (r_mode == MODE_STAND) begin
            blend_a = r_lie_rd;
            blend_b = r_std_rd;
        end else begin
            blend_a = r_cap_rd;
            blend_b = r_lie_rd;
        end
        diff = $signed({1'b0, blend_b ^ ANGLE_HALF}) - $signed({1'b0, blend_a ^ ANGLE_HALF});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= diff * $signed({1'b0, r_ramp});
            r_base <= blend_a ^ ANGLE_HALF;
        end
    end

    assign blend_sum = {4'b0, r_base, ANGLE_HALF} + {r_prod[ANGLE_W+RAMP_W+1], r_prod};
    assign blend_out = blend_sum[2*ANGLE_W-1:ANGLE_W] ^ ANGLE_HALF;

    // Output register
    t_out_item r_out;
    logic      r_out_vld;
    logic      idx_last;

    assign idx_last = (r_idx == IDX_W'(JOINT_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.out_joint    <= JOINT_W'(r_idx);
            r_out.current_mode <= r_mode;
            r_out.last         <= idx_last;
            case (r_mode)
                MODE_LIE, MODE_STAND: begin
                    r_out.target_position <= blend_out;
                    r_out.gain_set        <= 1'b1;
                    r_out.driven          <= 1'b1;
                end
                MODE_DEFAULT: begin
                    r_out.target_position <= '0;
                    r_out.gain_set        <= 1'b0;
                    r_out.driven          <= 1'b1;
                end
                default: begin
                    r_out.target_position <= '0;
                    r_out.gain_set        <= 1'b0;
                    r_out.driven          <= 1'b0;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign o_sts.item_is_tick  = (ev == EV_TICK);
    assign o_sts.item_captures = ev_capture;
    assign o_sts.idx_last      = idx_last;
    assign o_sts.out_taken     = r_out_vld && i_out_ready;

endmodule

@@ design/robot_posture_mode_sequencer_top.sv @@
// Top level of the posture mode sequencer: controller plus datapath.
`timescale 1ns / 1ps
// Sequencing: after a tick item is accepted, each joint in turn is read, multiplied,
// loaded into the output register and handed over, so a tick holds the input until
// its last joint command is taken. Other events are taken straight from idle; an
// event that captures holds the input for the copy sweep over the measured store.
// One item is in flight at a time.
// Reset (synchronous, active low) restores default mode, the register defaults
// and an all-zero measured store; pose and captured stores are not cleared.

module robot_posture_mode_sequencer_top import rpms_pkg::*; #(
    parameter int JOINT_COUNT = JOINT_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input items: events, samples, pose loads and ticks
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    // Result items: one command per joint on each tick
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    // Register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RAMP_W-1:0]    i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // Registers are to be written only while idle; the block does not enforce this, so always take the write
    assign o_cfg_ready = 1'b1;

    // Sequence the item: accept, sweep capture, or walk the joints
    rpms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Hold mode state, stores, blend arithmetic and the output register
    rpms_dp #(
        .JOINT_COUNT (JOINT_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
